// File: rtl/hfl_pkg.sv
// ----------------------------------------------------------------------------
// hfl_pkg
// Shared types and constants for the header field locator: payload
// structs, configuration bundle and position and name sizes.
// ----------------------------------------------------------------------------
package hfl_pkg;

    // Width of the byte position counters inside a header block.
    localparam int POS_BITS = 16;
    // Largest number of name characters compared before the colon.
    localparam int NAME_MAX = 16;
    // The line position saturates at NAME_MAX + 1.
    localparam int LINE_BITS = $clog2(NAME_MAX + 2);
    // The name registers always hold sixteen characters.
    localparam int NAME_CHARS = 16;
    localparam int NAME_IDX_BITS = $clog2(NAME_CHARS);

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 64;
    localparam int NAME_LEN_BITS = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_NAME_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NAME_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NAME_LEN  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } in_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic        too_long;
    } out_item_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] name_chars_low;
        logic [CFG_DATA_BITS-1:0] name_chars_high;
        logic [NAME_LEN_BITS-1:0] name_length;
    } cfg_t;

endpackage

// File: rtl/header_field_locator_core.sv
// ----------------------------------------------------------------------------
// header_field_locator_core
// Finds one configured field name in a header block streamed one byte per
// item and reports the trimmed value's offset and length at the block end.
// ----------------------------------------------------------------------------
// Result path: a block's last byte sits in the input register, and the
//   result register loads the block's result item when that byte is
//   processed, which waits while the result register is full and stalled.
// Throughput: one byte per cycle while no block end waits on a full result
//   register; each byte's scan is a combinational compare and counter update.
// Reset: rst_n clears the name registers, the scan state and both valid flags.
module header_field_locator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  hfl_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output hfl_pkg::out_item_t                 out_data,
    input  logic                               cfg_write,
    input  logic [hfl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hfl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import hfl_pkg::*;

    // Input register. It holds one byte while the scan logic works on it.
    logic      in_valid_reg;
    in_item_t  in_item_reg;

    // Result register. It parts the scan from the downstream consumer, so
    // bytes keep flowing while a finished result waits to be taken.
    logic      out_valid_reg;
    out_item_t out_item_reg;

    cfg_t      cfg;
    out_item_t scan_result;
    logic      proc_fire;

    // A byte that does not end a block produces no result and always moves on.
    // The last byte of a block needs a free slot in the result register, which
    // is the case when it is empty or being taken in this cycle.
    assign proc_fire = in_valid_reg &&
                       (!in_item_reg.block_end || !out_valid_reg || !out_stall);

    // The input register refills in the same cycle that its byte is consumed.
    assign in_stall = in_valid_reg && !proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_data;
        end
    end

    hfl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hfl_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (proc_fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (scan_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && in_item_reg.block_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_item_reg.block_end)
        begin
            out_item_reg <= scan_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

// File: rtl/hfl_cfg.sv
// ----------------------------------------------------------------------------
// hfl_cfg
// Configuration registers: the field name characters and name length.
// ----------------------------------------------------------------------------
module hfl_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [hfl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [hfl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output hfl_pkg::cfg_t                      cfg
);
    import hfl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NAME_LOW:  cfg_reg.name_chars_low  <= cfg_data;
                REG_NAME_HIGH: cfg_reg.name_chars_high <= cfg_data;
                REG_NAME_LEN:  cfg_reg.name_length     <= cfg_data[NAME_LEN_BITS-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/hfl_scan.sv
// ----------------------------------------------------------------------------
// hfl_scan
// Per-block scan state and the combinational update for one header byte.
// ----------------------------------------------------------------------------
module hfl_scan (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  hfl_pkg::in_item_t  item,
    input  hfl_pkg::cfg_t      cfg,
    output hfl_pkg::out_item_t result
);
    import hfl_pkg::*;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [LINE_BITS-1:0] LINE_SAT = LINE_BITS'(NAME_MAX + 1);
    localparam logic [NAME_LEN_BITS-1:0] NAME_CAP = NAME_LEN_BITS'(NAME_MAX);

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c | CASE_BIT;
        return c;
    endfunction

    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 first_reg, first_next;
    logic                 prefix_reg, prefix_next;
    logic                 in_value_reg, in_value_next;
    logic                 has_text_reg, has_text_next;
    logic [POS_BITS-1:0]  vstart_reg, vstart_next;
    logic [POS_BITS-1:0]  vstop_reg, vstop_next;
    logic                 prev_cr_reg, prev_cr_next;
    logic                 done_reg, done_next;

    logic [7:0]          name_bytes [NAME_CHARS];
    logic [7:0]          name_char;
    logic [7:0]          b;
    logic                last;
    logic                overflow;
    logic [POS_BITS-1:0] p1;
    logic [POS_BITS-1:0] fin_end;
    logic [LINE_BITS-1:0] nlen;
    logic                found;

    always_comb
    begin
        for (int i = 0; i < NAME_CHARS / 2; i++)
        begin
            name_bytes[i]                  = cfg.name_chars_low[i*8 +: 8];
            name_bytes[i + NAME_CHARS / 2] = cfg.name_chars_high[i*8 +: 8];
        end
    end

    assign name_char = name_bytes[line_reg[NAME_IDX_BITS-1:0]];
    assign nlen = LINE_BITS'((cfg.name_length > NAME_CAP) ? NAME_CAP : cfg.name_length);
    assign b = item.data_byte;
    assign last = item.block_end;
    // The position saturates at all ones; from there on bytes are not examined.
    assign overflow = &pos_reg;
    assign p1 = pos_reg + POS_BITS'(1);

    always_comb
    begin
        pos_next      = pos_reg;
        line_next     = line_reg;
        first_next    = first_reg;
        prefix_next   = prefix_reg;
        in_value_next = in_value_reg;
        has_text_next = has_text_reg;
        vstart_next   = vstart_reg;
        vstop_next    = vstop_reg;
        prev_cr_next  = prev_cr_reg;
        done_next     = done_reg;
        fin_end       = '0;

        if (!overflow)
        begin
            pos_next = p1;
            if (done_reg)
            begin
                // Bytes after the search ends are ignored until the block end.
            end
            else if (first_reg)
            begin
                if (b == CH_LF)
                begin
                    first_next   = 1'b0;
                    line_next    = '0;
                    prefix_next  = 1'b1;
                    prev_cr_next = 1'b0;
                end
            end
            else if (in_value_reg)
            begin
                if (b == CH_LF)
                begin
                    fin_end = prev_cr_reg ? pos_reg - POS_BITS'(1) : pos_reg;
                    if (!has_text_reg)
                    begin
                        vstart_next = fin_end;
                        vstop_next  = fin_end;
                    end
                    done_next = 1'b1;
                end
                else
                begin
                    // A held-back CR that is followed by more bytes is value text.
                    if (prev_cr_reg)
                    begin
                        if (!has_text_next)
                            vstart_next = pos_reg - POS_BITS'(1);
                        vstop_next    = pos_reg;
                        has_text_next = 1'b1;
                    end
                    prev_cr_next = (b == CH_CR);
                    if (b != CH_CR && b != CH_SPACE && b != CH_TAB)
                    begin
                        if (!has_text_next)
                            vstart_next = pos_reg;
                        vstop_next    = p1;
                        has_text_next = 1'b1;
                    end
                    if (last)
                    begin
                        fin_end = prev_cr_next ? pos_reg : p1;
                        if (!has_text_next)
                        begin
                            vstart_next = fin_end;
                            vstop_next  = fin_end;
                        end
                        done_next = 1'b1;
                    end
                end
            end
            else if (b == CH_LF)
            begin
                // An empty line, or one holding only a CR, ends the header.
                if (line_reg == '0 || (line_reg == LINE_BITS'(1) && prev_cr_reg))
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    line_next    = '0;
                    prefix_next  = 1'b1;
                    prev_cr_next = 1'b0;
                end
            end
            else
            begin
                prev_cr_next = (b == CH_CR);
                if (prefix_reg && line_reg < nlen)
                begin
                    if (fold(b) != fold(name_char))
                        prefix_next = 1'b0;
                end
                else if (prefix_reg && line_reg == nlen)
                begin
                    if (b == CH_COLON)
                    begin
                        in_value_next = 1'b1;
                        has_text_next = 1'b0;
                        prev_cr_next  = 1'b0;
                        if (last)
                        begin
                            vstart_next = p1;
                            vstop_next  = p1;
                            done_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        prefix_next = 1'b0;
                    end
                end
                if (!(prefix_reg && line_reg == nlen && b == CH_COLON) && line_reg < LINE_SAT)
                    line_next = line_reg + LINE_BITS'(1);
            end
        end
    end

    assign found = !overflow && done_next && in_value_next;

    always_comb
    begin
        result.found        = found;
        result.value_offset = found ? 16'(vstart_next) : 16'd0;
        result.value_length = found ? 16'(vstop_next - vstart_next) : 16'd0;
        result.too_long     = overflow;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            line_reg     <= '0;
            first_reg    <= 1'b1;
            prefix_reg   <= 1'b1;
            in_value_reg <= 1'b0;
            has_text_reg <= 1'b0;
            vstart_reg   <= '0;
            vstop_reg    <= '0;
            prev_cr_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else if (fire)
        begin
            if (last)
            begin
                pos_reg      <= '0;
                line_reg     <= '0;
                first_reg    <= 1'b1;
                prefix_reg   <= 1'b1;
                in_value_reg <= 1'b0;
                has_text_reg <= 1'b0;
                vstart_reg   <= '0;
                vstop_reg    <= '0;
                prev_cr_reg  <= 1'b0;
                done_reg     <= 1'b0;
            end
            else
            begin
                pos_reg      <= pos_next;
                line_reg     <= line_next;
                first_reg    <= first_next;
                prefix_reg   <= prefix_next;
                in_value_reg <= in_value_next;
                has_text_reg <= has_text_next;
                vstart_reg   <= vstart_next;
                vstop_reg    <= vstop_next;
                prev_cr_reg  <= prev_cr_next;
                done_reg     <= done_next;
            end
        end
    end

endmodule
